// ===== rtl/bfsk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and sine table math for the binary FSK tone generator.
// No dependencies.
package bfsk_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int AMP_W      = 15;
    localparam int SINE_W     = 15;
    localparam int SAMPLE_W   = 16;
    localparam int CHAR_W     = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_MARK_STEP  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPACE_STEP = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] MARK_STEP_RST  = 32'd42949673;
    localparam logic [CFG_DATA_W-1:0] SPACE_STEP_RST = 32'd64424509;
    localparam logic [AMP_W-1:0]      AMPLITUDE_RST  = 15'd32000;

    localparam logic [CHAR_W-1:0] CHAR_MARK  = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h30;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic valid;
        logic neg;
        logic last;
    } bfsk_tag_t;

    // Q0.15 sine of k/2^abits quarter turns via a fixed-point Taylor series.
    function automatic logic [SINE_W-1:0] sine_q15(input int unsigned k,
                                                   input int unsigned abits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint unsigned v;
        longint          sum;
        x   = (longint'(k) * HALF_PI_Q30) >> abits;
        x2  = (x * x) >> 30;
        mag = x;
        sum = longint'(x);
        mag = ((mag * x2) >> 30) / 6;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 20;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 42;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 72;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 110;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 156;
        sum = sum + longint'(mag);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = longint'(unsigned'(sum + 16384)) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/bfsk_phase.sv =====
`timescale 1ns / 1ps
// Phase accumulators for mark and space tones, quarter-wave address generation.
// Depends on bfsk_pkg.
module bfsk_phase #(
    parameter int PHASE_WIDTH    = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [bfsk_pkg::CHAR_W-1:0]         bit_char,
    input  logic                                last_in,
    input  logic [bfsk_pkg::CFG_DATA_W-1:0]     mark_step,
    input  logic [bfsk_pkg::CFG_DATA_W-1:0]     space_step,
    output logic [SINE_ADDR_BITS:0]             rom_addr,
    output bfsk_pkg::bfsk_tag_t                 tag
);

    localparam logic [SINE_ADDR_BITS:0] QTR = (SINE_ADDR_BITS+1)'(1) << SINE_ADDR_BITS;

    logic [PHASE_WIDTH-1:0]    mark_phase_reg;
    logic [PHASE_WIDTH-1:0]    mark_phase_next;
    logic [PHASE_WIDTH-1:0]    space_phase_reg;
    logic [PHASE_WIDTH-1:0]    space_phase_next;
    logic [PHASE_WIDTH-1:0]    phase;
    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic                      is_mark;
    logic                      is_bit;
    logic                      emit;
    bfsk_pkg::bfsk_tag_t       tag_reg;

    assign is_mark = (bit_char == bfsk_pkg::CHAR_MARK);
    assign is_bit  = is_mark || (bit_char == bfsk_pkg::CHAR_SPACE);
    assign emit    = in_valid && en && is_bit;

    assign phase = is_mark ? mark_phase_reg : space_phase_reg;
    assign quad  = phase[PHASE_WIDTH-1 -: 2];
    assign idx   = phase[PHASE_WIDTH-3 -: SINE_ADDR_BITS];

    always_comb
    begin
        if (quad[0])
        begin
            rom_addr = QTR - {1'b0, idx};
        end
        else
        begin
            rom_addr = {1'b0, idx};
        end
    end

    assign mark_phase_next  = mark_phase_reg + PHASE_WIDTH'(mark_step);
    assign space_phase_next = space_phase_reg + PHASE_WIDTH'(space_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_phase_reg  <= '0;
            space_phase_reg <= '0;
            tag_reg         <= '0;
        end
        else
        begin
            if (emit)
            begin
                mark_phase_reg  <= mark_phase_next;
                space_phase_reg <= space_phase_next;
            end
            if (en)
            begin
                tag_reg.valid <= in_valid && is_bit;
                tag_reg.neg   <= quad[1];
                tag_reg.last  <= last_in;
            end
        end
    end

    assign tag = tag_reg;

endmodule

// ===== rtl/bfsk_sine_rom.sv =====
`timescale 1ns / 1ps
// Quarter-wave Q0.15 sine ROM with a registered read.
// Depends on bfsk_pkg for the table function.
module bfsk_sine_rom #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [SINE_ADDR_BITS:0]           addr,
    output logic [bfsk_pkg::SINE_W-1:0]       data
);

    localparam int DEPTH = (1 << SINE_ADDR_BITS) + 1;

    typedef logic [bfsk_pkg::SINE_W-1:0] rom_t [0:DEPTH-1];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < DEPTH; k++)
        begin
            r[k] = bfsk_pkg::sine_q15(k, SINE_ADDR_BITS);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [bfsk_pkg::SINE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

// ===== rtl/bfsk_scale.sv =====
`timescale 1ns / 1ps
// Amplitude multiply, sign restore and output register of the tone generator.
// Depends on bfsk_pkg.
module bfsk_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bfsk_pkg::bfsk_tag_t                 tag,
    input  logic [bfsk_pkg::SINE_W-1:0]         rom_data,
    input  logic [bfsk_pkg::AMP_W-1:0]          amplitude,
    output logic                                ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bfsk_pkg::SAMPLE_W-1:0]       sample,
    output logic                                last_out
);

    localparam int PROD_W = bfsk_pkg::AMP_W + bfsk_pkg::SINE_W;

    logic [PROD_W-1:0]             prod_reg;
    logic [PROD_W-1:0]             prod_next;
    logic                          p2_valid_reg;
    logic                          p2_neg_reg;
    logic                          p2_last_reg;
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic [bfsk_pkg::SAMPLE_W-1:0] sample_reg;
    logic [bfsk_pkg::SAMPLE_W-1:0] sample_next;
    logic [bfsk_pkg::AMP_W-1:0]    mag;
    logic                          en_out;
    logic                          en2;

    assign en_out = !out_valid_reg || out_ready;
    assign en2    = !p2_valid_reg || en_out;

    assign prod_next = {{bfsk_pkg::SINE_W{1'b0}}, amplitude}
                     * {{bfsk_pkg::AMP_W{1'b0}}, rom_data};

    assign mag = prod_reg[PROD_W-1 -: bfsk_pkg::AMP_W];

    always_comb
    begin
        if (p2_neg_reg)
        begin
            sample_next = bfsk_pkg::SAMPLE_W'(0) - {1'b0, mag};
        end
        else
        begin
            sample_next = {1'b0, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                p2_valid_reg <= tag.valid;
            end
            if (en_out)
            begin
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod_reg    <= prod_next;
            p2_neg_reg  <= tag.neg;
            p2_last_reg <= tag.last;
        end
        if (en_out)
        begin
            sample_reg   <= sample_next;
            out_last_reg <= p2_last_reg;
        end
    end

    assign ready     = en2;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last_out  = out_last_reg;

`ifndef ASSERT_OFF
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en2 |-> (p2_valid_reg && out_valid_reg && !out_ready))
        else $error("scale stage stalled with room downstream");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (tag.valid && en2) |=> p2_valid_reg)
        else $error("word lost between ROM stage and multiply stage");

    a_out_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && en_out) |=> out_valid_reg)
        else $error("word lost between multiply stage and output");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg != 16'h8000 && sample_reg != 16'h8001
                           && sample_reg != 16'h7FFF))
        else $error("sample magnitude above 32766");
`endif

endmodule

// ===== rtl/binary_fsk_tone_generator_core.sv =====
`timescale 1ns / 1ps
// Binary FSK tone generator, top level.
// Depends on bfsk_pkg, bfsk_phase, bfsk_sine_rom, bfsk_scale.
//
// Input stream (s_*): one word per sample slot; s_tdata[7:0] holds an ASCII
// character, s_tlast marks the final character of a bit string. A '1' yields
// one mark-tone sample, a '0' one space-tone sample; any other character is
// taken and dropped without moving the tone phases.
// Output stream (m_*): m_tdata[15:0] is the signed sample, m_tlast copies the
// last flag of the character that produced it.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 mark step,
// 1 space step, 2 amplitude); other indexes are ignored. Write only while idle.
// A word accepted on s_* is registered in turn in the sine ROM register, the
// product register and the output register, which drives m_tvalid. Throughput is
// one word per cycle while m_tready stays high.
// Reset clears both phase accumulators and loads the default steps and amplitude.
// When m_tready is low the three stages fill up; s_tready falls only once all of
// them hold a word, and no word is lost or repeated.
module binary_fsk_tone_generator_core #(
    parameter int PHASE_WIDTH    = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bfsk_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bfsk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] bit_char
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] sample
    output logic                                m_tlast
);

    logic [bfsk_pkg::CFG_DATA_W-1:0] mark_step_reg;
    logic [bfsk_pkg::CFG_DATA_W-1:0] space_step_reg;
    logic [bfsk_pkg::AMP_W-1:0]      amplitude_reg;
    logic [SINE_ADDR_BITS:0]         rom_addr;
    logic [bfsk_pkg::SINE_W-1:0]     rom_data;
    bfsk_pkg::bfsk_tag_t             tag;
    logic                            en2;
    logic                            en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_step_reg  <= bfsk_pkg::MARK_STEP_RST;
            space_step_reg <= bfsk_pkg::SPACE_STEP_RST;
            amplitude_reg  <= bfsk_pkg::AMPLITUDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bfsk_pkg::REG_MARK_STEP:  mark_step_reg  <= cfg_wdata;
                bfsk_pkg::REG_SPACE_STEP: space_step_reg <= cfg_wdata;
                bfsk_pkg::REG_AMPLITUDE:  amplitude_reg  <= cfg_wdata[bfsk_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign en1      = !tag.valid || en2;
    assign s_tready = en1;

    bfsk_phase #(
        .PHASE_WIDTH    (PHASE_WIDTH),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en1),
        .in_valid   (s_tvalid),
        .bit_char   (s_tdata),
        .last_in    (s_tlast),
        .mark_step  (mark_step_reg),
        .space_step (space_step_reg),
        .rom_addr   (rom_addr),
        .tag        (tag)
    );

    bfsk_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (en1),
        .addr (rom_addr),
        .data (rom_data)
    );

    bfsk_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .rom_data  (rom_data),
        .amplitude (amplitude_reg),
        .ready     (en2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sample    (m_tdata),
        .last_out  (m_tlast)
    );

endmodule
